@@ hw/rtl/dnp_pkg.sv @@
// Shared types and constants for the DNS entry name decompression parser.
// Used by the parser core and its testbench; depends on nothing.
`default_nettype none
package dnp_pkg;

   localparam int DEF_STORE_DEPTH      = 512;
   localparam int DEF_MAX_POINTER_HOPS = 16;
   localparam int DEF_MAX_NAME_CHARS   = 255;

   // wide enough for a 14-bit pointer target plus a label
   localparam int IDX_WIDTH = 16;
   localparam int NAME_AW   = 8;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   typedef enum logic [1:0] {
      MODE_WRITE    = 2'd0,
      MODE_QUESTION = 2'd1,
      MODE_RECORD   = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ERR_OK       = 2'd0,
      ERR_HOPS     = 2'd1,
      ERR_RANGE    = 2'd2,
      ERR_TOO_LONG = 2'd3
   } error_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN_REQ,
      ST_LEN_WAIT,
      ST_PTR_WAIT,
      ST_CHR_REQ,
      ST_CHR_WAIT,
      ST_FIX_CHK,
      ST_FIX_REQ,
      ST_FIX_WAIT,
      ST_SUM_CHK,
      ST_CK_REQ,
      ST_CK_WAIT,
      ST_CK_OUT,
      ST_SUM_OUT,
      ST_ERR_OUT
   } state_type;

endpackage
`default_nettype wire

@@ hw/rtl/dnp_req_if.sv @@
// Request channel: valid/ready handshake with mode, address and data byte.
// Depends on nothing.
`default_nettype none
interface dnp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [8:0] address;
   logic [7:0] data_byte;

   modport source (output valid, mode, address, data_byte, input ready);
   modport sink   (input valid, mode, address, data_byte, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dnp_rsp_if.sv @@
// Response channel: name chunks and the final entry summary.
// Depends on nothing.
`default_nettype none
interface dnp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] name_chunk;
   logic [3:0]  chunk_bytes;
   logic [15:0] rtype;
   logic [15:0] rclass;
   logic [31:0] ttl;
   logic [15:0] rdata_length;
   logic [8:0]  rdata_start;
   logic [8:0]  next_index;
   logic [7:0]  name_length;
   logic [1:0]  error;
   logic        last;

   modport source (output valid, kind, name_chunk, chunk_bytes, rtype, rclass, ttl,
                   rdata_length, rdata_start, next_index, name_length, error, last,
                   input ready);
   modport sink   (input valid, kind, name_chunk, chunk_bytes, rtype, rclass, ttl,
                   rdata_length, rdata_start, next_index, name_length, error, last,
                   output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dns_entry_name_decompress_parser_core.sv @@
// Operation: a write stores one byte. A parse reads each length byte and name character,
// follows pointers through their low byte, reads the fixed field bytes, reads the name
// back from the name buffer while chunks are packed, then sends the result beats.
// Throughput: one request at a time; the single read ports of the store and name buffer set the pace.
// Reset: synchronous, clears the sequencer; store contents are undefined until written.
// Depends on dnp_pkg, dnp_req_if and dnp_rsp_if.
`default_nettype none
module dns_entry_name_decompress_parser_core
   import dnp_pkg::*;
#(
   parameter int STORE_DEPTH      = DEF_STORE_DEPTH,
   parameter int MAX_POINTER_HOPS = DEF_MAX_POINTER_HOPS,
   parameter int MAX_NAME_CHARS   = DEF_MAX_NAME_CHARS
) (
   input  wire logic   clock,
   input  wire logic   reset,
   dnp_req_if.sink     req_bus,
   dnp_rsp_if.source   rsp_bus
);

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int HW = $clog2(MAX_POINTER_HOPS + 1);
   localparam logic [IDX_WIDTH-1:0] DEPTH_I = IDX_WIDTH'(STORE_DEPTH);

   // memories
   logic [7:0] store_mem [0:STORE_DEPTH-1];
   logic [7:0] name_mem  [0:(1 << NAME_AW)-1];

   state_type state_ff, state_in;
   logic                 rec_ff, rec_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic [IDX_WIDTH-1:0] end_ff, end_in;
   logic                 jumped_ff, jumped_in;
   logic [HW-1:0]        hops_ff, hops_in;
   logic [7:0]           len_ff, len_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [5:0]           ptrhi_ff, ptrhi_in;
   logic [1:0]           err_ff, err_in;
   logic [79:0]          fix_ff, fix_in;
   logic [3:0]           fcnt_ff, fcnt_in;
   logic [8:0]           pos_ff, pos_in;
   logic [2:0]           k_ff, k_in;
   logic [63:0]          chunk_ff, chunk_in;
   logic [7:0]           rd_ff;
   logic [7:0]           nb_rd_ff;

   // memory controls
   logic           st_we;
   logic [AW-1:0]  st_waddr;
   logic           st_re;
   logic [AW-1:0]  st_raddr;
   logic           nb_we;
   logic [7:0]     nb_wdata;
   logic           nb_re;
   logic [7:0]     nb_raddr;

   logic [9:0]           grow;
   logic [IDX_WIDTH-1:0] lbl_end;
   logic [3:0]           need;
   logic [17:0]          rec_next;
   logic [7:0]           rp;
   logic [8:0]           pos_step;

   assign grow     = 10'(len_ff) + 10'(rd_ff) + ((len_ff != 8'd0) ? 10'd1 : 10'd0);
   assign lbl_end  = idx_ff + IDX_WIDTH'(1) + IDX_WIDTH'(rd_ff);
   assign need     = rec_ff ? 4'd10 : 4'd4;
   assign rec_next = 18'(end_ff) + 18'd10 + 18'(fix_ff[15:0]);
   assign rp       = pos_ff[7:0] + 8'(k_ff);
   assign pos_step = pos_ff + 9'd8;

   // next state and datapath
   always_comb begin
      state_in  = state_ff;
      rec_in    = rec_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      jumped_in = jumped_ff;
      hops_in   = hops_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      ptrhi_in  = ptrhi_ff;
      err_in    = err_ff;
      fix_in    = fix_ff;
      fcnt_in   = fcnt_ff;
      pos_in    = pos_ff;
      k_in      = k_ff;
      chunk_in  = chunk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.mode == MODE_QUESTION || req_bus.mode == MODE_RECORD) begin
                  rec_in    = (req_bus.mode == MODE_RECORD);
                  idx_in    = IDX_WIDTH'(req_bus.address);
                  end_in    = '0;
                  jumped_in = 1'b0;
                  hops_in   = '0;
                  len_in    = '0;
                  err_in    = ERR_OK;
                  state_in  = ST_LEN_REQ;
               end
            end
         end
         ST_LEN_REQ: begin
            if (idx_ff >= DEPTH_I) begin
               err_in   = ERR_RANGE;
               state_in = ST_ERR_OUT;
            end else begin
               state_in = ST_LEN_WAIT;
            end
         end
         ST_LEN_WAIT: begin
            if (rd_ff == 8'd0) begin
               if (!jumped_ff) end_in = idx_ff + IDX_WIDTH'(1);
               state_in = ST_FIX_CHK;
            end else if (rd_ff[7:6] != 2'b00) begin
               if (32'(hops_ff) >= 32'(MAX_POINTER_HOPS)) begin
                  err_in   = ERR_HOPS;
                  state_in = ST_ERR_OUT;
               end else if (idx_ff + IDX_WIDTH'(1) >= DEPTH_I) begin
                  err_in   = ERR_RANGE;
                  state_in = ST_ERR_OUT;
               end else begin
                  ptrhi_in = rd_ff[5:0];
                  state_in = ST_PTR_WAIT;
               end
            end else if (grow > 10'(MAX_NAME_CHARS)) begin
               err_in   = ERR_TOO_LONG;
               state_in = ST_ERR_OUT;
            end else if (lbl_end > DEPTH_I) begin
               err_in   = ERR_RANGE;
               state_in = ST_ERR_OUT;
            end else begin
               if (len_ff != 8'd0) len_in = len_ff + 8'd1;
               cnt_in   = rd_ff[5:0];
               idx_in   = idx_ff + IDX_WIDTH'(1);
               state_in = ST_CHR_REQ;
            end
         end
         ST_PTR_WAIT: begin
            if (!jumped_ff) begin
               end_in    = idx_ff + IDX_WIDTH'(2);
               jumped_in = 1'b1;
            end
            hops_in  = hops_ff + HW'(1);
            idx_in   = IDX_WIDTH'({ptrhi_ff, rd_ff});
            state_in = ST_LEN_REQ;
         end
         ST_CHR_REQ: begin
            state_in = ST_CHR_WAIT;
         end
         ST_CHR_WAIT: begin
            len_in = len_ff + 8'd1;
            idx_in = idx_ff + IDX_WIDTH'(1);
            cnt_in = cnt_ff - 6'd1;
            state_in = (cnt_ff == 6'd1) ? ST_LEN_REQ : ST_CHR_REQ;
         end
         ST_FIX_CHK: begin
            fcnt_in = '0;
            if (end_ff + IDX_WIDTH'(need) > DEPTH_I) begin
               err_in   = ERR_RANGE;
               state_in = ST_ERR_OUT;
            end else begin
               state_in = ST_FIX_REQ;
            end
         end
         ST_FIX_REQ: begin
            state_in = ST_FIX_WAIT;
         end
         ST_FIX_WAIT: begin
            fix_in  = {fix_ff[71:0], rd_ff};
            fcnt_in = fcnt_ff + 4'd1;
            state_in = (fcnt_ff + 4'd1 == need) ? ST_SUM_CHK : ST_FIX_REQ;
         end
         ST_SUM_CHK: begin
            pos_in   = '0;
            k_in     = '0;
            chunk_in = '0;
            if (rec_ff && rec_next > 18'(STORE_DEPTH)) begin
               err_in   = ERR_RANGE;
               state_in = ST_ERR_OUT;
            end else if (len_ff == 8'd0) begin
               state_in = ST_SUM_OUT;
            end else begin
               state_in = ST_CK_REQ;
            end
         end
         ST_CK_REQ: begin
            state_in = ST_CK_WAIT;
         end
         ST_CK_WAIT: begin
            chunk_in[8*k_ff +: 8] = nb_rd_ff;
            if (k_ff == 3'd7 || rp + 8'd1 == len_ff) begin
               state_in = ST_CK_OUT;
            end else begin
               k_in     = k_ff + 3'd1;
               state_in = ST_CK_REQ;
            end
         end
         ST_CK_OUT: begin
            if (rsp_bus.ready) begin
               if (pos_step >= 9'(len_ff)) begin
                  state_in = ST_SUM_OUT;
               end else begin
                  pos_in   = pos_step;
                  k_in     = '0;
                  chunk_in = '0;
                  state_in = ST_CK_REQ;
               end
            end
         end
         ST_SUM_OUT, ST_ERR_OUT: begin
            if (rsp_bus.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      req_bus.ready = (state_ff == ST_IDLE);
      st_we    = 1'b0;
      st_waddr = AW'(IDX_WIDTH'(req_bus.address));
      st_re    = 1'b0;
      st_raddr = idx_ff[AW-1:0];
      nb_we    = 1'b0;
      nb_wdata = rd_ff;
      nb_re    = 1'b0;
      nb_raddr = rp;

      rsp_bus.valid        = 1'b0;
      rsp_bus.kind         = 1'b0;
      rsp_bus.name_chunk   = '0;
      rsp_bus.chunk_bytes  = '0;
      rsp_bus.rtype        = '0;
      rsp_bus.rclass       = '0;
      rsp_bus.ttl          = '0;
      rsp_bus.rdata_length = '0;
      rsp_bus.rdata_start  = '0;
      rsp_bus.next_index   = '0;
      rsp_bus.name_length  = '0;
      rsp_bus.error        = '0;
      rsp_bus.last         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            st_we = req_bus.valid && (req_bus.mode == MODE_WRITE) &&
                    (IDX_WIDTH'(req_bus.address) < DEPTH_I);
            st_waddr = AW'(IDX_WIDTH'(req_bus.address));
         end
         ST_LEN_REQ: st_re = (idx_ff < DEPTH_I);
         ST_LEN_WAIT: begin
            // pointer low byte
            st_re    = 1'b1;
            st_raddr = AW'(idx_ff + IDX_WIDTH'(1));
            // separator before every label but the first
            nb_we    = (rd_ff != 8'd0) && (rd_ff[7:6] == 2'b00) && (len_ff != 8'd0)
                       && (grow <= 10'(MAX_NAME_CHARS)) && (lbl_end <= DEPTH_I);
            nb_wdata = DOT_CHAR;
         end
         ST_CHR_REQ: st_re = 1'b1;
         ST_CHR_WAIT: nb_we = 1'b1;
         ST_FIX_REQ: begin
            st_re    = 1'b1;
            st_raddr = AW'(end_ff + IDX_WIDTH'(fcnt_ff));
         end
         ST_CK_REQ: nb_re = 1'b1;
         ST_CK_OUT: begin
            rsp_bus.valid       = 1'b1;
            rsp_bus.name_chunk  = chunk_ff;
            rsp_bus.chunk_bytes = 4'(k_ff) + 4'd1;
         end
         ST_SUM_OUT: begin
            rsp_bus.valid       = 1'b1;
            rsp_bus.kind        = 1'b1;
            rsp_bus.last        = 1'b1;
            rsp_bus.name_length = len_ff;
            if (rec_ff) begin
               rsp_bus.rtype        = fix_ff[79:64];
               rsp_bus.rclass       = fix_ff[63:48];
               rsp_bus.ttl          = fix_ff[47:16];
               rsp_bus.rdata_length = fix_ff[15:0];
               rsp_bus.rdata_start  = 9'(end_ff + IDX_WIDTH'(10));
               rsp_bus.next_index   = rec_next[8:0];
            end else begin
               rsp_bus.rtype      = fix_ff[31:16];
               rsp_bus.rclass     = fix_ff[15:0];
               rsp_bus.next_index = 9'(end_ff + IDX_WIDTH'(4));
            end
         end
         ST_ERR_OUT: begin
            rsp_bus.valid = 1'b1;
            rsp_bus.kind  = 1'b1;
            rsp_bus.last  = 1'b1;
            rsp_bus.error = err_ff;
         end
         default: ;
      endcase
   end

   // message store: one write, one registered read
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_waddr] <= req_bus.data_byte;
      if (st_re) rd_ff <= store_mem[st_raddr];
   end

   // name buffer: one write, one registered read
   always_ff @(posedge clock) begin
      if (nb_we) name_mem[len_ff] <= nb_wdata;
      if (nb_re) nb_rd_ff <= name_mem[nb_raddr];
   end

   // advance sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rec_ff    <= rec_in;
      idx_ff    <= idx_in;
      end_ff    <= end_in;
      jumped_ff <= jumped_in;
      hops_ff   <= hops_in;
      len_ff    <= len_in;
      cnt_ff    <= cnt_in;
      ptrhi_ff  <= ptrhi_in;
      err_ff    <= err_in;
      fix_ff    <= fix_in;
      fcnt_ff   <= fcnt_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
      chunk_ff  <= chunk_in;
   end

endmodule
`default_nettype wire

@@ verif/tb_dns_entry_name_decompress_parser_core.sv @@
// Self-checking testbench for the DNS entry name decompression parser core.
// Drives store writes and parse requests, predicts name chunks and summaries.
// Depends on dnp_pkg, dnp_req_if, dnp_rsp_if and the parser core.
`default_nettype none
module tb_dns_entry_name_decompress_parser_core;
   import dnp_pkg::*;

   localparam int DEPTH      = 512;
   localparam int HOP_LIMIT  = 16;
   localparam int NAME_LIMIT = 255;
   localparam int RUN_LIMIT  = 5000000;
   localparam int TARGET_REQ = 470;

   typedef struct packed {
      logic        kind;
      logic [63:0] name_chunk;
      logic [3:0]  chunk_bytes;
      logic [15:0] rtype;
      logic [15:0] rclass;
      logic [31:0] ttl;
      logic [15:0] rdata_length;
      logic [8:0]  rdata_start;
      logic [8:0]  next_index;
      logic [7:0]  name_length;
      logic [1:0]  error;
      logic        last;
   } entry_beat_type;

   typedef struct {
      mode_type   mode;
      int         addr;
      int         data;
      bit         typed;
      int         rtype;
      int         rclass;
      int         next;
      error_type  err;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   dnp_req_if req_bus ();
   dnp_rsp_if rsp_bus ();

   dns_entry_name_decompress_parser_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #6 clock = ~clock;

   // local copy of the message store and which bytes hold written data
   logic [7:0]     store_copy [DEPTH];
   bit             store_written [DEPTH];
   entry_beat_type pending_beats [$];
   int             entry_starts [$];
   mode_type       entry_modes [$];

   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   int requests_sent = 0;
   int parses_sent = 0;
   int beats_seen = 0;
   int error_beats = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // walk one entry as the block does; clean is cleared on any unwritten read
   task automatic predict_entry(input mode_type mode, input int addr,
                                output bit clean, output entry_beat_type beats [$]);
      int idx, hops, len, end_idx, err, b, tgt, need, nxt, n;
      int rtype, rclass, ttl, rdlen, rdstart;
      bit jumped;
      logic [7:0] name [$];
      entry_beat_type beat;
      idx = addr; hops = 0; len = 0; end_idx = 0; err = ERR_OK; jumped = 0;
      ttl = 0; rdlen = 0; rdstart = 0;
      clean = 1;
      beats = {};
      forever begin
         if (idx >= DEPTH) begin
            err = ERR_RANGE;
            break;
         end
         if (!store_written[idx]) clean = 0;
         b = store_copy[idx];
         if (b == 0) begin
            if (!jumped) end_idx = idx + 1;
            break;
         end
         if ((b & 8'hC0) != 0) begin
            if (hops >= HOP_LIMIT) begin
               err = ERR_HOPS;
               break;
            end
            if (idx + 1 >= DEPTH) begin
               err = ERR_RANGE;
               break;
            end
            if (!store_written[idx + 1]) clean = 0;
            tgt = ((b & 8'h3F) << 8) | store_copy[idx + 1];
            if (!jumped) begin
               end_idx = idx + 2;
               jumped = 1;
            end
            hops++;
            idx = tgt;
            continue;
         end
         if (len + b + (len > 0 ? 1 : 0) > NAME_LIMIT) begin
            err = ERR_TOO_LONG;
            break;
         end
         if (idx + 1 + b > DEPTH) begin
            err = ERR_RANGE;
            break;
         end
         if (len > 0) begin
            name.push_back(DOT_CHAR);
            len++;
         end
         for (int k = 0; k < b; k++) begin
            if (!store_written[idx + 1 + k]) clean = 0;
            name.push_back(store_copy[idx + 1 + k]);
         end
         len += b;
         idx += 1 + b;
      end
      need = (mode == MODE_QUESTION) ? 4 : 10;
      if (err == ERR_OK && end_idx + need > DEPTH) err = ERR_RANGE;
      if (err == ERR_OK) begin
         for (int k = 0; k < need; k++)
            if (!store_written[end_idx + k]) clean = 0;
         rtype  = {store_copy[end_idx], store_copy[end_idx + 1]};
         rclass = {store_copy[end_idx + 2], store_copy[end_idx + 3]};
         nxt = end_idx + 4;
         if (mode == MODE_RECORD) begin
            ttl = {store_copy[end_idx + 4], store_copy[end_idx + 5],
                   store_copy[end_idx + 6], store_copy[end_idx + 7]};
            rdlen = {store_copy[end_idx + 8], store_copy[end_idx + 9]};
            rdstart = end_idx + 10;
            nxt = rdstart + rdlen;
            if (nxt > DEPTH) err = ERR_RANGE;
         end
      end
      beat = '0;
      beat.kind = 1'b1;
      beat.last = 1'b1;
      if (err != ERR_OK) begin
         beat.error = err[1:0];
         beats.push_back(beat);
         return;
      end
      // pack the dotted name, eight characters per chunk
      for (int pos = 0; pos < len; pos += 8) begin
         entry_beat_type chunk;
         chunk = '0;
         n = (len - pos < 8) ? len - pos : 8;
         for (int k = 0; k < n; k++) chunk.name_chunk[8 * k +: 8] = name[pos + k];
         chunk.chunk_bytes = n[3:0];
         beats.push_back(chunk);
      end
      beat.rtype        = rtype[15:0];
      beat.rclass       = rclass[15:0];
      beat.ttl          = ttl;
      beat.rdata_length = rdlen[15:0];
      beat.rdata_start  = rdstart[8:0];
      beat.next_index   = nxt[8:0];
      beat.name_length  = len[7:0];
      beats.push_back(beat);
   endtask

   // hold one request on the bus until the block takes it
   task automatic drive_request(input mode_type mode, input int addr, input int data);
      int gap;
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.address   <= addr[8:0];
      req_bus.data_byte <= data[7:0];
      do @(posedge clock); while (!req_bus.ready);
      requests_sent++;
   endtask

   task automatic write_byte(input int addr, input int data);
      if (addr >= DEPTH) return;
      store_copy[addr] = data[7:0];
      store_written[addr] = 1;
      drive_request(MODE_WRITE, addr, data);
   endtask

   // predict and send a parse; drop it if it would read unwritten bytes
   task automatic parse_entry(input mode_type mode, input int addr);
      bit clean;
      entry_beat_type beats [$];
      predict_entry(mode, addr, clean, beats);
      if (!clean) return;
      foreach (beats[i]) pending_beats.push_back(beats[i]);
      parses_sent++;
      drive_request(mode, addr, $urandom_range(255));
   endtask

   // lay out one entry, mostly well-formed, at a random place, then parse it
   task automatic build_entry();
      int base, p, labels, l, tgt, need, rdlen;
      mode_type mode;
      base = $urandom_range(0, 500);
      mode = $urandom_range(1) ? MODE_RECORD : MODE_QUESTION;
      p = base;
      labels = $urandom_range(0, 3);
      for (int i = 0; i < labels; i++) begin
         l = ($urandom_range(15) == 0) ? 63 : $urandom_range(1, 8);
         write_byte(p++, l);
         for (int k = 0; k < l; k++) write_byte(p++, $urandom_range(1, 255));
      end
      if (entry_starts.size() > 0 && $urandom_range(2) == 0) begin
         tgt = entry_starts[$urandom_range(entry_starts.size() - 1)];
         write_byte(p++, 8'hC0 | (tgt >> 8));
         write_byte(p++, tgt & 8'hFF);
      end else if ($urandom_range(19) == 0) begin
         // odd pointer forms and far targets
         write_byte(p++, $urandom_range(64, 255));
         write_byte(p++, $urandom_range(255));
      end else begin
         write_byte(p++, 0);
      end
      need = (mode == MODE_QUESTION) ? 4 : 10;
      for (int k = 0; k < need - 2; k++) write_byte(p++, $urandom_range(255));
      rdlen = ($urandom_range(7) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(6);
      if (mode == MODE_RECORD) begin
         p -= 2;
         write_byte(p++, rdlen >> 8);
         write_byte(p++, rdlen & 8'hFF);
      end
      entry_starts.push_back(base);
      entry_modes.push_back(mode);
      parse_entry(mode, base);
   endtask

   function automatic stim_row_type row(mode_type m, int a, int d, bit t = 0, int rt = 0,
                                        int rc = 0, int nx = 0, error_type e = ERR_OK);
      stim_row_type r;
      r.mode = m; r.addr = a; r.data = d; r.typed = t;
      r.rtype = rt; r.rclass = rc; r.next = nx; r.err = e;
      return r;
   endfunction

   // check each accepted response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         entry_beat_type got, exp_beat;
         got = {rsp_bus.kind, rsp_bus.name_chunk, rsp_bus.chunk_bytes, rsp_bus.rtype,
                rsp_bus.rclass, rsp_bus.ttl, rsp_bus.rdata_length, rsp_bus.rdata_start,
                rsp_bus.next_index, rsp_bus.name_length, rsp_bus.error, rsp_bus.last};
         beats_seen++;
         if (got.kind && got.error != ERR_OK) error_beats++;
         if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: %p", got);
         end else begin
            exp_beat = pending_beats.pop_front();
            if (got !== exp_beat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at cycle %0d\n  expected %p\n  actual   %p",
                           cycle_count, exp_beat, got);
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      entry_beat_type typed_beat;
      int phase;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_WRITE;
      req_bus.address = '0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      foreach (store_written[i]) begin
         store_written[i] = 0;
         store_copy[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: pointer loop, reads past the end, root names, unused mode
      rows = '{
         row(MODE_WRITE, 0, 8'hC0), row(MODE_WRITE, 1, 8'h00),
         row(MODE_QUESTION, 0, 0, 1, 0, 0, 0, ERR_HOPS),
         row(MODE_WRITE, 511, 8'h05),
         row(MODE_QUESTION, 511, 0, 1, 0, 0, 0, ERR_RANGE),
         row(MODE_WRITE, 2, 8'hFF), row(MODE_WRITE, 3, 8'hFF),
         row(MODE_RECORD, 2, 0, 1, 0, 0, 0, ERR_RANGE),
         row(MODE_WRITE, 10, 8'h00), row(MODE_WRITE, 11, 8'hFF),
         row(MODE_WRITE, 12, 8'hFF), row(MODE_WRITE, 13, 8'hFF),
         row(MODE_WRITE, 14, 8'hFF),
         row(MODE_QUESTION, 10, 8'hFF, 1, 16'hFFFF, 16'hFFFF, 15, ERR_OK),
         row(MODE_NONE, 10, 0),
         row(MODE_WRITE, 4, 8'h00), row(MODE_WRITE, 5, 8'h00),
         row(MODE_WRITE, 6, 8'h00), row(MODE_WRITE, 7, 8'h00),
         row(MODE_WRITE, 8, 8'h01),
         row(MODE_QUESTION, 4, 0, 1, 16'h0000, 16'h0001, 9, ERR_OK)
      };
      foreach (rows[i]) begin
         if (rows[i].mode == MODE_WRITE) begin
            write_byte(rows[i].addr, rows[i].data);
         end else if (rows[i].typed) begin
            typed_beat = '0;
            typed_beat.kind = 1'b1;
            typed_beat.last = 1'b1;
            typed_beat.rtype = rows[i].rtype[15:0];
            typed_beat.rclass = rows[i].rclass[15:0];
            typed_beat.next_index = rows[i].next[8:0];
            typed_beat.error = rows[i].err;
            pending_beats.push_back(typed_beat);
            parses_sent++;
            drive_request(rows[i].mode, rows[i].addr, rows[i].data);
         end else begin
            drive_request(rows[i].mode, rows[i].addr, rows[i].data);
         end
      end

      // a 63-character label that points back at itself overruns the name limit
      write_byte(100, 63);
      for (int k = 0; k < 63; k++) write_byte(101 + k, $urandom_range(8'h61, 8'h7A));
      write_byte(164, 8'hC0);
      write_byte(165, 100);
      parse_entry(MODE_QUESTION, 100);

      // random part in four idling phases
      while (requests_sent < TARGET_REQ || beats_seen + pending_beats.size() < 60) begin
         phase = (requests_sent * 4 / TARGET_REQ) % 4;
         send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 56 : 27) : 0;
         sink_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 56 : 27) : 0;
         case ($urandom_range(19))
            0: drive_request(MODE_NONE, $urandom_range(511), $urandom_range(255));
            1: parse_entry(mode_type'($urandom_range(1, 2)), $urandom_range(511));
            2, 3, 4, 5, 6, 7: begin
               if (entry_starts.size() > 0) begin
                  int pick;
                  pick = $urandom_range(entry_starts.size() - 1);
                  parse_entry(entry_modes[pick], entry_starts[pick]);
               end
            end
            default: build_entry();
         endcase
      end
      req_bus.valid <= 1'b0;

      while (pending_beats.size() > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d requests with %0d parses; %0d responses checked, %0d error summaries",
               requests_sent, parses_sent, beats_seen, error_beats);
      $display("idling phases: none, sender gaps, receiver stalls, both");
      if (mismatches == 0 && pending_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire
